[sv/pce_pkg.sv]
package pce_pkg;

   localparam int MAX_SIZE_DEF = 16;

   // fixed field widths of the request / response transactions
   localparam int FUNC_W     = 3;
   localparam int POS_W      = 5;
   localparam int STEP_W     = 4;
   localparam int VAL_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index is paddr[2]
   localparam logic REG_ACTIVE_SIZE = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_IDENTITY = 3'd0,
      FUNC_SWAP     = 3'd1,
      FUNC_FIX      = 3'd2,
      FUNC_CYC_LEFT = 3'd3,
      FUNC_CYC_RGHT = 3'd4,
      FUNC_READ     = 3'd5
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWAP_RDX,
      ST_SWAP_RDY,
      ST_SWAP_WRX,
      ST_SWAP_WRY,
      ST_ROT_FIRST,
      ST_ROT_SAVE,
      ST_ROT_READ,
      ST_ROT_WRITE,
      ST_ROT_LAST,
      ST_REBUILD,
      ST_REB_DRAIN,
      ST_RES_READ,
      ST_RES_CAP
   } state_type;

endpackage

[sv/pce_ifs.sv]
interface pce_req_if
   import pce_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [POS_W-1:0]  first_pos;
   logic [POS_W-1:0]  last_pos;
   logic [STEP_W-1:0] step_index;
   logic [VAL_W-1:0]  item_value;

   modport source (output valid, func, first_pos, last_pos, step_index, item_value,
                   input ready);
   modport sink   (input valid, func, first_pos, last_pos, step_index, item_value,
                   output ready);
endinterface

interface pce_rsp_if
   import pce_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] perm_value;
   logic [VAL_W-1:0] inverse_value;
   logic             arg_error;

   modport source (output valid, perm_value, inverse_value, arg_error, input ready);
   modport sink   (input valid, perm_value, inverse_value, arg_error, output ready);
endinterface

[sv/pce_ram.sv]
module pce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/permutation_cycle_engine_unit.sv]
// Permutation cycle engine: holds a permutation p of 1..n and its inverse q in two
// small RAMs, both starting as the identity (per-entry valid bits make reset, the
// identity request and any active_size write take effect at once). A request swaps,
// fixes or rotates entries through one read and one write port per RAM, then walks
// the changed array once to rebuild the other, and returns both entries at first_pos.
// One request is in flight at a time; req ready is high only while idle. The rebuild
// walk reads one entry per cycle over n = active_size entries, and each RAM has a
// single read port. The response sits in an output register, so a new request
// is taken while the previous response waits.
module permutation_cycle_engine_unit
   import pce_pkg::*;
#(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pce_req_if.sink               req_bus,
   pce_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(MAX_SIZE);
   localparam int EW = $clog2(MAX_SIZE + 1);
   localparam int CW = (EW > POS_W) ? EW : POS_W;
   localparam int RESET_SIZE = (16 <= MAX_SIZE) ? 16 : MAX_SIZE;

   state_type         state_ff, state_in;
   logic [AW-1:0]     idx_ff, idx_in, end_ff, end_in, x_ff, x_in, y_ff, y_in;
   logic [AW-1:0]     pend_idx_ff, pend_idx_in;
   logic              dir_dn_ff, dir_dn_in, pend_ff, pend_in;
   logic              src_inv_ff, src_inv_in, lookup_ff, lookup_in;
   logic [EW-1:0]     tmp_ff, tmp_in;
   logic [EW-1:0]     size_ff, size_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              pos_ok_ff, pos_ok_in, err_ff, err_in;
   logic [VAL_W-1:0]  perm_out_ff, perm_out_in, inv_out_ff, inv_out_in;
   logic              err_out_ff, err_out_in, rsp_valid_ff, rsp_valid_in;

   logic [MAX_SIZE-1:0] p_vld_ff, q_vld_ff;
   logic              rd_vld_p_ff, rd_vld_q_ff;
   logic [AW-1:0]     rd_addr_p_ff, rd_addr_q_ff;

   logic              p_we, q_we, s_we, d_we;
   logic [AW-1:0]     p_waddr, q_waddr, s_waddr, d_waddr;
   logic [AW-1:0]     p_raddr, q_raddr, s_raddr, d_raddr;
   logic [EW-1:0]     p_wdata, q_wdata, s_wdata, d_wdata;
   logic [EW-1:0]     p_rdata, q_rdata, p_val, q_val, s_val, d_val;
   logic [EW-1:0]     s_val_m1, d_val_m1;
   logic [CW-1:0]     p_ext, q_ext;

   logic              cfg_wr, clear_vld, accept, rsp_load;
   logic [CW-1:0]     n_c, j_c, q_c, v_c, s_c, a_c, n_m1_c, j_m1_c, q_m1_c, v_m1_c, cfg_c;
   logic              step_bad, rng_bad, j_ok;
   logic [AW-1:0]     idx_nb, pos_m1;
   logic [CW-1:0]     pos_m1_c;

   pce_ram #(.WIDTH(EW), .DEPTH(MAX_SIZE)) u_perm_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   pce_ram #(.WIDTH(EW), .DEPTH(MAX_SIZE)) u_inv_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   // source/destination routing: source is q only for the right cycle
   assign p_we    = src_inv_ff ? d_we    : s_we;
   assign p_waddr = src_inv_ff ? d_waddr : s_waddr;
   assign p_wdata = src_inv_ff ? d_wdata : s_wdata;
   assign p_raddr = src_inv_ff ? d_raddr : s_raddr;
   assign q_we    = src_inv_ff ? s_we    : d_we;
   assign q_waddr = src_inv_ff ? s_waddr : d_waddr;
   assign q_wdata = src_inv_ff ? s_wdata : d_wdata;
   assign q_raddr = src_inv_ff ? s_raddr : d_raddr;

   // never-written entries read as identity
   assign p_val = rd_vld_p_ff ? p_rdata : EW'(rd_addr_p_ff) + EW'(1);
   assign q_val = rd_vld_q_ff ? q_rdata : EW'(rd_addr_q_ff) + EW'(1);
   assign s_val = src_inv_ff ? q_val : p_val;
   assign d_val = src_inv_ff ? p_val : q_val;
   assign s_val_m1 = s_val - EW'(1);
   assign d_val_m1 = d_val - EW'(1);
   assign p_ext = CW'(p_val);
   assign q_ext = CW'(q_val);

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_ACTIVE_SIZE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ACTIVE_SIZE) ? CSR_DATA_W'(size_ff) : '0;

   always_comb begin
      cfg_c = CW'(csr_pwdata[POS_W-1:0]);
      if (cfg_c == '0) begin
         size_in = EW'(1);
      end else if (cfg_c > CW'(MAX_SIZE)) begin
         size_in = EW'(MAX_SIZE);
      end else begin
         size_in = cfg_c[EW-1:0];
      end
   end

   // argument checks on the incoming transaction
   assign n_c    = CW'(size_ff);
   assign j_c    = CW'(req_bus.first_pos);
   assign q_c    = CW'(req_bus.last_pos);
   assign v_c    = CW'(req_bus.item_value);
   assign s_c    = CW'(req_bus.step_index);
   assign a_c    = n_c - CW'(1) - s_c;
   assign n_m1_c = n_c - CW'(1);
   assign j_m1_c = j_c - CW'(1);
   assign q_m1_c = q_c - CW'(1);
   assign v_m1_c = v_c - CW'(1);
   assign step_bad = (s_c >= n_c) || (v_c == '0) || (v_c > n_c);
   assign rng_bad  = (j_c == '0) || (q_c == '0) || (j_c > n_c) || (q_c > n_c) || (j_c > q_c);
   assign j_ok     = (j_c != '0) && (j_c <= n_c);

   assign idx_nb   = dir_dn_ff ? idx_ff - AW'(1) : idx_ff + AW'(1);
   assign pos_m1_c = CW'(pos_ff) - CW'(1);
   assign pos_m1   = pos_m1_c[AW-1:0];

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      end_in      = end_ff;
      dir_dn_in   = dir_dn_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      tmp_in      = tmp_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      src_inv_in  = src_inv_ff;
      lookup_in   = lookup_ff;
      pos_in      = pos_ff;
      pos_ok_in   = pos_ok_ff;
      err_in      = err_ff;
      clear_vld   = 1'b0;
      rsp_load    = 1'b0;
      s_we        = 1'b0;
      s_waddr     = idx_ff;
      s_wdata     = tmp_ff;
      s_raddr     = idx_ff;
      d_we        = 1'b0;
      d_waddr     = s_val_m1[AW-1:0];
      d_wdata     = EW'(pend_idx_ff) + EW'(1);
      d_raddr     = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in     = req_bus.first_pos;
               pos_ok_in  = j_ok;
               src_inv_in = 1'b0;
               lookup_in  = 1'b0;
               dir_dn_in  = 1'b0;
               x_in       = a_c[AW-1:0];
               y_in       = v_m1_c[AW-1:0];
               err_in     = 1'b0;
               state_in   = ST_RES_READ;
               case (func_type'(req_bus.func))
                  FUNC_IDENTITY: begin
                     clear_vld = 1'b1;
                  end
                  FUNC_SWAP: begin
                     err_in = step_bad;
                     if (!step_bad) begin
                        state_in = ST_SWAP_RDX;
                     end
                  end
                  FUNC_FIX: begin
                     err_in    = step_bad;
                     lookup_in = 1'b1;
                     if (!step_bad) begin
                        state_in = ST_LOOKUP;
                     end
                  end
                  FUNC_CYC_LEFT: begin
                     err_in    = rng_bad;
                     idx_in    = q_m1_c[AW-1:0];
                     end_in    = j_m1_c[AW-1:0];
                     dir_dn_in = 1'b1;
                     if (!rng_bad) begin
                        state_in = ST_ROT_FIRST;
                     end
                  end
                  FUNC_CYC_RGHT: begin
                     err_in = rng_bad;
                     idx_in = j_m1_c[AW-1:0];
                     end_in = q_m1_c[AW-1:0];
                     if (!rng_bad) begin
                        src_inv_in = 1'b1;
                        state_in   = ST_ROT_FIRST;
                     end
                  end
                  FUNC_READ: begin
                     err_in = !j_ok;
                  end
                  default: begin
                     err_in = 1'b1;
                  end
               endcase
            end
         end
         // fixed value: its position comes from the inverse
         ST_LOOKUP: begin
            d_raddr  = y_ff;
            state_in = ST_SWAP_RDX;
         end
         ST_SWAP_RDX: begin
            s_raddr = x_ff;
            if (lookup_ff) begin
               y_in = d_val_m1[AW-1:0];
            end
            state_in = ST_SWAP_RDY;
         end
         ST_SWAP_RDY: begin
            s_raddr  = y_ff;
            tmp_in   = s_val;
            state_in = ST_SWAP_WRX;
         end
         ST_SWAP_WRX: begin
            s_we     = 1'b1;
            s_waddr  = x_ff;
            s_wdata  = s_val;
            state_in = ST_SWAP_WRY;
         end
         ST_SWAP_WRY: begin
            s_we      = 1'b1;
            s_waddr   = y_ff;
            s_wdata   = tmp_ff;
            idx_in    = '0;
            dir_dn_in = 1'b0;
            pend_in   = 1'b0;
            state_in  = ST_REBUILD;
         end
         ST_ROT_FIRST: begin
            s_raddr  = idx_ff;
            state_in = ST_ROT_SAVE;
         end
         ST_ROT_SAVE: begin
            tmp_in   = s_val;
            state_in = ST_ROT_READ;
         end
         ST_ROT_READ: begin
            if (idx_ff == end_ff) begin
               state_in = ST_ROT_LAST;
            end else begin
               s_raddr  = idx_nb;
               state_in = ST_ROT_WRITE;
            end
         end
         ST_ROT_WRITE: begin
            s_we     = 1'b1;
            s_waddr  = idx_ff;
            s_wdata  = s_val;
            idx_in   = idx_nb;
            state_in = ST_ROT_READ;
         end
         ST_ROT_LAST: begin
            s_we      = 1'b1;
            s_waddr   = idx_ff;
            s_wdata   = tmp_ff;
            idx_in    = '0;
            dir_dn_in = 1'b0;
            pend_in   = 1'b0;
            state_in  = ST_REBUILD;
         end
         // read src[i] each cycle, write dst[src[i]-1] = i+1 in the cycle after
         ST_REBUILD: begin
            s_raddr     = idx_ff;
            d_we        = pend_ff;
            pend_in     = 1'b1;
            pend_idx_in = idx_ff;
            if (idx_ff == n_m1_c[AW-1:0]) begin
               state_in = ST_REB_DRAIN;
            end else begin
               idx_in = idx_nb;
            end
         end
         ST_REB_DRAIN: begin
            d_we     = 1'b1;
            pend_in  = 1'b0;
            state_in = ST_RES_READ;
         end
         ST_RES_READ: begin
            s_raddr  = pos_m1;
            d_raddr  = pos_m1;
            state_in = ST_RES_CAP;
         end
         ST_RES_CAP: begin
            s_raddr = pos_m1;
            d_raddr = pos_m1;
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      perm_out_in = perm_out_ff;
      inv_out_in  = inv_out_ff;
      err_out_in  = err_out_ff;
      if (rsp_load) begin
         perm_out_in = pos_ok_ff ? p_ext[VAL_W-1:0] : '0;
         inv_out_in  = pos_ok_ff ? q_ext[VAL_W-1:0] : '0;
         err_out_in  = err_ff;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.perm_value    = perm_out_ff;
   assign rsp_bus.inverse_value = inv_out_ff;
   assign rsp_bus.arg_error     = err_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         src_inv_ff   <= 1'b0;
         size_ff      <= EW'(RESET_SIZE);
         p_vld_ff     <= '0;
         q_vld_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         src_inv_ff   <= src_inv_in;
         if (cfg_wr) begin
            size_ff <= size_in;
         end
         if (cfg_wr || clear_vld) begin
            p_vld_ff <= '0;
            q_vld_ff <= '0;
         end else begin
            if (p_we) begin
               p_vld_ff[p_waddr] <= 1'b1;
            end
            if (q_we) begin
               q_vld_ff[q_waddr] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      end_ff       <= end_in;
      dir_dn_ff    <= dir_dn_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      tmp_ff       <= tmp_in;
      pend_idx_ff  <= pend_idx_in;
      lookup_ff    <= lookup_in;
      pos_ff       <= pos_in;
      pos_ok_ff    <= pos_ok_in;
      err_ff       <= err_in;
      perm_out_ff  <= perm_out_in;
      inv_out_ff   <= inv_out_in;
      err_out_ff   <= err_out_in;
      rd_vld_p_ff  <= p_vld_ff[p_raddr];
      rd_vld_q_ff  <= q_vld_ff[q_raddr];
      rd_addr_p_ff <= p_raddr;
      rd_addr_q_ff <= q_raddr;
   end

   // a taken transaction always leaves idle in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but engine stayed idle");

   // RAM writes only come from the swap, rotate and rebuild steps
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      (p_we || q_we) |-> (state_ff == ST_SWAP_WRX || state_ff == ST_SWAP_WRY ||
                          state_ff == ST_ROT_WRITE || state_ff == ST_ROT_LAST ||
                          state_ff == ST_REBUILD || state_ff == ST_REB_DRAIN))
      else $error("RAM write outside an update step");

   // pending rebuild write never leaks out of the rebuild walk
   a_pend_scope: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_REBUILD || state_ff == ST_REB_DRAIN))
      else $error("rebuild write pending outside rebuild");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      (size_ff != '0) && (CW'(size_ff) <= CW'(MAX_SIZE)))
      else $error("active size out of range");

endmodule
